// ===== hw/rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg - shared definitions for the double-ended queue
// Operation codes, status codes and controller state type.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 9;

    // operation codes
    localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] OP_READ_IDX   = 3'd4;
    localparam logic [MODE_W-1:0] OP_WRITE_IDX  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } dq_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/double_ended_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_top - bounded deque of elements in a ring buffer
// Push/pop at either end plus indexed read and write, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: tuser carries the operation code, tdata the
//   value and the index. Output channel m_axis_*: tdata carries the popped
//   or read element and the element count, tuser the status code.
//   Every accepted item yields exactly one result item.
// Timing / throughput:
//   Pushes, writes, errors and unused codes: result valid the cycle after
//   acceptance, one item per cycle sustained if the receiver keeps up.
//   Successful pops and reads: the ring memory has a registered read port,
//   so the element goes through rd_data_reg and the S_READ state to the
//   output register; no new item is taken while in S_READ.
// Reset:
//   Asynchronous, active low. The queue comes up empty (head and count
//   zero); memory contents are not cleared and need no clearing pass,
//   since only entries filled by a push or write can be read.
// Stall:
//   A result waits in the output register while m_axis_tready is low; no
//   new item is taken until that register is free or being drained.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] value, [15:8] index
    input  wire logic [dq_pkg::MODE_W-1:0] s_axis_tuser, // [2:0] mode
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] data_out, [16:8] count, rest 0
    output logic [dq_pkg::STATUS_W-1:0] m_axis_tuser // [1:0] status
);
    import dq_pkg::*;

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // ring pointer
    localparam int CW = $clog2(CAPACITY + 1);                     // element count
    localparam int EW = (CW > BYTE_W) ? CW : BYTE_W;              // compare width
    localparam int XW = (DATA_WIDTH > BYTE_W) ? DATA_WIDTH : BYTE_W;

    // ring storage, one port, registered read
    logic [DATA_WIDTH-1:0] ring_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    dq_state_t      state_reg, state_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_data_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] index;
    logic              accept;

    logic [EW-1:0]   offset;
    logic [EW:0]     pos_sum;
    logic [PW-1:0]   pos;
    logic [PW-1:0]   head_dec;
    logic            full, empty, idx_bad;

    logic            mem_we, mem_re, is_read;
    logic [PW-1:0]   mem_addr;
    logic [STATUS_W-1:0] status_c;
    logic [XW-1:0]   value_x, rd_x;

    assign mode  = s_axis_tuser;
    assign value = s_axis_tdata[7:0];
    assign index = s_axis_tdata[15:8];

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign idx_bad = (EW'(index) >= EW'(count_reg));

    // ring position = (head + offset) mod CAPACITY, valid for offset up to CAPACITY
    always_comb
    begin
        case (mode)
            OP_PUSH_BACK: offset = EW'(count_reg);
            OP_POP_FRONT: offset = EW'(1);
            OP_POP_BACK:  offset = EW'(count_reg) - EW'(1);
            default:      offset = EW'(index);
        endcase
    end

    assign pos_sum  = (EW+1)'(head_reg) + (EW+1)'(offset);
    assign pos      = (pos_sum >= (EW+1)'(CAPACITY)) ? PW'(pos_sum - (EW+1)'(CAPACITY))
                                                     : PW'(pos_sum);
    assign head_dec = (head_reg == '0) ? PW'(CAPACITY - 1) : head_reg - PW'(1);

    // operation decode; errors leave head and count untouched
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = pos;
        is_read    = 1'b0;
        status_c   = ST_OK;
        unique case (mode)
            OP_PUSH_FRONT:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                    mem_addr   = head_dec;
                    mem_we     = 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    count_next = count_reg + CW'(1);
                    mem_we     = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else
                begin
                    mem_addr   = head_reg;
                    mem_re     = 1'b1;
                    is_read    = 1'b1;
                    head_next  = pos;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else
                begin
                    mem_re     = 1'b1;
                    is_read    = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ_IDX:
            begin
                if (idx_bad)
                    status_c = ST_RANGE;
                else
                begin
                    mem_re  = 1'b1;
                    is_read = 1'b1;
                end
            end
            OP_WRITE_IDX:
            begin
                if (idx_bad)
                    status_c = ST_RANGE;
                else
                    mem_we = 1'b1;
            end
            default: ;  // unused codes: ok, no change
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept && is_read) state_next = S_READ;
            S_READ: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign value_x = XW'(value);
    assign rd_x    = XW'(rd_data_reg);

    // memory port
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
            ring_mem[mem_addr] <= value_x[DATA_WIDTH-1:0];
        if (accept && mem_re)
            rd_data_reg <= ring_mem[mem_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (accept)
                out_valid_reg <= !is_read;       // reads finish from the S_READ state
            else if (state_reg == S_READ)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= '0;
            out_count_reg  <= COUNT_W'(count_next);
            out_status_reg <= status_c;
        end
        else if (state_reg == S_READ)
            out_data_reg <= rd_x[BYTE_W-1:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_count_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
`default_nettype wire
